// File: rtl/rkm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkm_pkg: shared types for the RSA key/modexp block
// Controller states, datapath operation codes, command and status bundles.
// ----------------------------------------------------------------------------
package rkm_pkg;

  localparam int unsigned NW  = 32;  // residue / modulus width
  localparam int unsigned EW  = 5;   // public exponent width
  localparam int unsigned CW  = 16;  // config register width
  localparam int unsigned DVW = 64;  // dividend width
  localparam int unsigned AW  = 38;  // private exponent search accumulator

  typedef enum logic [4:0] {
    S_IDLE, S_KEY_PQ, S_KEY_FN, S_KEY_CHK,
    S_GCD_SET, S_GCD_TEST, S_GCD_WAIT,
    S_ACC_INIT, S_ACC_DIV, S_ACC_WAIT,
    S_EXP_INIT, S_VAL_WAIT, S_LOOP,
    S_R_DIV, S_R_WAIT, S_MUL_B, S_B_DIV, S_B_WAIT,
    S_DONE
  } state_e;

  typedef enum logic [4:0] {
    DP_NOP, DP_LATCH, DP_MUL_PQ, DP_MUL_PMQM, DP_LD_FN, DP_KEY_TRIV,
    DP_GCD_SET, DP_GCD_STEP, DP_E_INC, DP_ACC_INIT, DP_ACC_ADD, DP_D_LD,
    DP_EXP_INIT, DP_BASE_LD, DP_RES_ZERO, DP_MUL_RB, DP_RES_LD,
    DP_MUL_BB, DP_BASE_SQ
  } dp_op_e;

  typedef enum logic [1:0] {
    DIV_GCD, DIV_ACC, DIV_VAL, DIV_PROD
  } div_sel_e;

  typedef struct packed {
    dp_op_e   op;
    logic     div_start;
    div_sel_e div_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic key_ready;
    logic prod_lo_zero;
    logic b_zero;
    logic a_one;
    logic e_is30;
    logic rem_zero;
    logic n_zero;
    logic exp_zero;
    logic exp_lsb;
    logic div_done;
    logic div_busy;
  } dp_sts_t;

endpackage

// File: rtl/rkm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkm_div: radix-2 restoring divider
// 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rkm_div
  import rkm_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [NW-1:0]  divisor_i,
  output logic           busy_o,
  output logic           done_o,
  output logic [DVW-1:0] quo_o,
  output logic [NW-1:0]  rem_o
);

  logic           run_q, done_q;
  logic [5:0]     cnt_q;
  logic [DVW-1:0] quo_q;
  logic [NW-1:0]  rem_q, div_q;
  logic [NW:0]    trial;
  logic           ge;
  logic [NW-1:0]  rem_d;

  always_comb begin
    trial = {rem_q, quo_q[DVW-1]};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? NW'(trial - {1'b0, div_q}) : trial[NW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[DVW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign busy_o = run_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/rkm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkm_datapath: key and exponentiation registers
// Config registers, 32x32 multiplier, shared divider, key and work registers.
// ----------------------------------------------------------------------------
module rkm_datapath
  import rkm_pkg::*;
#(
  parameter int unsigned PRIME_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [CW-1:0] cfg_wdata_i,
  input  logic          op_i,
  input  logic [NW-1:0] value_i,
  input  dp_cmd_t       cmd_i,
  output dp_sts_t       sts_o,
  output logic [NW-1:0] result_o,
  output logic [NW-1:0] modulus_o,
  output logic [EW-1:0] public_exponent_o,
  output logic [NW-1:0] private_exponent_o
);

  localparam int unsigned MB = (PRIME_BITS < CW) ? PRIME_BITS : CW;
  localparam logic [CW-1:0] PMask = CW'((17'(1) << MB) - 17'(1));

  logic [CW-1:0]  p_q, q_q, pm, qm, pv, qv;
  logic [NW-1:0]  n_q, fn_q, d_q, a_q, b_q, base_q, res_q, exp_q, val_q;
  logic [EW-1:0]  e_q;
  logic           ready_q, op_q;
  logic [AW-1:0]  acc_q;
  logic [2*NW-1:0] prod_q;
  logic [NW-1:0]  mul_a, mul_b;
  logic [DVW-1:0] dv_x;
  logic [NW-1:0]  dv_y;
  logic           dv_busy, dv_done;
  logic [DVW-1:0] dv_quo;
  logic [NW-1:0]  dv_rem;

  assign pv = p_q & PMask;
  assign qv = q_q & PMask;
  assign pm = (pv != '0) ? pv - CW'(1) : '0;
  assign qm = (qv != '0) ? qv - CW'(1) : '0;

  always_comb begin
    case (cmd_i.op)
      DP_MUL_PQ: begin
        mul_a = NW'(pv);
        mul_b = NW'(qv);
      end
      DP_MUL_PMQM: begin
        mul_a = NW'(pm);
        mul_b = NW'(qm);
      end
      DP_MUL_RB: begin
        mul_a = res_q;
        mul_b = base_q;
      end
      default: begin
        mul_a = base_q;
        mul_b = base_q;
      end
    endcase
    case (cmd_i.div_sel)
      DIV_GCD: begin
        dv_x = DVW'(a_q);
        dv_y = b_q;
      end
      DIV_ACC: begin
        dv_x = DVW'(acc_q);
        dv_y = NW'(e_q);
      end
      DIV_VAL: begin
        dv_x = DVW'(val_q);
        dv_y = n_q;
      end
      default: begin
        dv_x = prod_q;
        dv_y = n_q;
      end
    endcase
  end

  rkm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dv_x),
    .divisor_i  (dv_y),
    .busy_o     (dv_busy),
    .done_o     (dv_done),
    .quo_o      (dv_quo),
    .rem_o      (dv_rem)
  );

  // Config, keys, key-valid flag; config writes stale the key; key loads win.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q     <= CW'(61);
      q_q     <= CW'(53);
      ready_q <= 1'b0;
      n_q     <= '0;
      e_q     <= '0;
      d_q     <= '0;
      fn_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        if (!cfg_idx_i) p_q <= cfg_wdata_i;
        else            q_q <= cfg_wdata_i;
        ready_q <= 1'b0;
      end
      case (cmd_i.op)
        DP_MUL_PMQM: n_q <= prod_q[NW-1:0];
        DP_LD_FN: begin
          fn_q <= prod_q[NW-1:0];
          e_q  <= EW'(2);
        end
        DP_KEY_TRIV: begin
          fn_q    <= '0;
          e_q     <= EW'(1);
          d_q     <= NW'(1);
          ready_q <= 1'b1;
        end
        DP_E_INC: e_q <= e_q + EW'(1);
        DP_D_LD: begin
          d_q     <= dv_quo[NW-1:0];
          ready_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LATCH: begin
        op_q  <= op_i;
        val_q <= value_i;
      end
      DP_MUL_PQ, DP_MUL_PMQM, DP_MUL_RB, DP_MUL_BB: prod_q <= mul_a * mul_b;
      DP_GCD_SET: begin
        a_q <= fn_q;
        b_q <= NW'(e_q);
      end
      DP_GCD_STEP: begin
        a_q <= b_q;
        b_q <= dv_rem;
      end
      DP_ACC_INIT: acc_q <= AW'(1) + AW'(fn_q);
      DP_ACC_ADD:  acc_q <= acc_q + AW'(fn_q);
      DP_EXP_INIT: begin
        exp_q <= op_q ? NW'(e_q) : d_q;
        res_q <= (n_q == NW'(1)) ? '0 : NW'(1);
      end
      DP_BASE_LD:  base_q <= dv_rem;
      DP_RES_ZERO: res_q  <= '0;
      DP_RES_LD:   res_q  <= dv_rem;
      DP_BASE_SQ: begin
        base_q <= dv_rem;
        exp_q  <= exp_q >> 1;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.key_ready    = ready_q;
    sts_o.prod_lo_zero = prod_q[NW-1:0] == '0;
    sts_o.b_zero       = b_q == '0;
    sts_o.a_one        = a_q == NW'(1);
    sts_o.e_is30       = e_q == EW'(30);
    sts_o.rem_zero     = dv_rem == '0;
    sts_o.n_zero       = n_q == '0;
    sts_o.exp_zero     = exp_q == '0;
    sts_o.exp_lsb      = exp_q[0];
    sts_o.div_done     = dv_done;
    sts_o.div_busy     = dv_busy;
  end

  assign result_o           = res_q;
  assign modulus_o          = n_q;
  assign public_exponent_o  = e_q;
  assign private_exponent_o = d_q;

endmodule

// File: rtl/rkm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkm_ctrl: sequencer for key derivation and square-and-multiply
// Issues one datapath operation per cycle and waits on the divider.
// ----------------------------------------------------------------------------
module rkm_ctrl
  import rkm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  output logic    done_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (start) state_d = sts_i.key_ready ? S_EXP_INIT : S_KEY_PQ;
      S_KEY_PQ:   state_d = S_KEY_FN;
      S_KEY_FN:   state_d = S_KEY_CHK;
      S_KEY_CHK:  state_d = sts_i.prod_lo_zero ? S_EXP_INIT : S_GCD_SET;
      S_GCD_SET:  state_d = S_GCD_TEST;
      S_GCD_TEST: begin
        if (!sts_i.b_zero)                   state_d = S_GCD_WAIT;
        else if (sts_i.a_one || sts_i.e_is30) state_d = S_ACC_INIT;
        else                                  state_d = S_GCD_SET;
      end
      S_GCD_WAIT: if (sts_i.div_done) state_d = S_GCD_TEST;
      S_ACC_INIT: state_d = S_ACC_DIV;
      S_ACC_DIV:  state_d = S_ACC_WAIT;
      S_ACC_WAIT: if (sts_i.div_done) state_d = sts_i.rem_zero ? S_EXP_INIT : S_ACC_DIV;
      S_EXP_INIT: state_d = sts_i.n_zero ? S_DONE : S_VAL_WAIT;
      S_VAL_WAIT: if (sts_i.div_done) state_d = S_LOOP;
      S_LOOP: begin
        if (sts_i.exp_zero)     state_d = S_DONE;
        else if (sts_i.exp_lsb) state_d = S_R_DIV;
        else                    state_d = S_B_DIV;
      end
      S_R_DIV:    state_d = S_R_WAIT;
      S_R_WAIT:   if (sts_i.div_done) state_d = S_MUL_B;
      S_MUL_B:    state_d = S_B_DIV;
      S_B_DIV:    state_d = S_B_WAIT;
      S_B_WAIT:   if (sts_i.div_done) state_d = S_LOOP;
      S_DONE:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op        = DP_NOP;
    cmd_o.div_start = 1'b0;
    cmd_o.div_sel   = DIV_PROD;
    unique case (state_q)
      S_IDLE:     if (start) cmd_o.op = DP_LATCH;
      S_KEY_PQ:   cmd_o.op = DP_MUL_PQ;
      S_KEY_FN:   cmd_o.op = DP_MUL_PMQM;
      S_KEY_CHK:  cmd_o.op = sts_i.prod_lo_zero ? DP_KEY_TRIV : DP_LD_FN;
      S_GCD_SET:  cmd_o.op = DP_GCD_SET;
      S_GCD_TEST: begin
        if (!sts_i.b_zero) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_GCD;
        end else if (!sts_i.a_one) begin
          cmd_o.op = DP_E_INC;
        end
      end
      S_GCD_WAIT: if (sts_i.div_done) cmd_o.op = DP_GCD_STEP;
      S_ACC_INIT: cmd_o.op = DP_ACC_INIT;
      S_ACC_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_ACC;
      end
      S_ACC_WAIT: if (sts_i.div_done) cmd_o.op = sts_i.rem_zero ? DP_D_LD : DP_ACC_ADD;
      S_EXP_INIT: begin
        if (sts_i.n_zero) begin
          cmd_o.op = DP_RES_ZERO;
        end else begin
          cmd_o.op        = DP_EXP_INIT;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_VAL;
        end
      end
      S_VAL_WAIT: if (sts_i.div_done) cmd_o.op = DP_BASE_LD;
      S_LOOP: begin
        if (!sts_i.exp_zero) cmd_o.op = sts_i.exp_lsb ? DP_MUL_RB : DP_MUL_BB;
      end
      S_R_DIV:    cmd_o.div_start = 1'b1;
      S_R_WAIT:   if (sts_i.div_done) cmd_o.op = DP_RES_LD;
      S_MUL_B:    cmd_o.op = DP_MUL_BB;
      S_B_DIV:    cmd_o.div_start = 1'b1;
      S_B_WAIT:   if (sts_i.div_done) cmd_o.op = DP_BASE_SQ;
      S_DONE:     ;
      default:    ;
    endcase
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = state_q == S_DONE;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe longer than one cycle");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy)
    else $error("divider started while running");

  a_key_before_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VAL_WAIT) |-> sts_i.key_ready)
    else $error("exponentiation without a derived key");

endmodule

// File: rtl/rsa_keygen_and_modexp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_keygen_and_modexp: textbook RSA key derivation and modular power
// Derives n, e, d from two configured factors, then raises each request value
// to d (op 0) or e (op 1) modulo n.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  request  | start, busy          | op_i, value_i
//  result   | done_o (strobe)      | result_o, modulus_o, public_exponent_o,
//           |                      | private_exponent_o
//  config   | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// Pacing: one request at a time. The shared divider sets the pace: the
//   request value is reduced once, each exponent bit costs a squaring and
//   its reduction, and each set bit a multiply and a reduction more, so a
//   request runs longer with more bits and more ones in its exponent, and
//   far shorter for the public exponent than for the private one.
// Key derivation on the first request after reset or a config write adds a
//   gcd search (a few divides per candidate e) and up to e trial divides.
// Reset: config returns to p = 61, q = 53 and the key is marked stale.
// Stalls: the receiver cannot stall; done_o is high for exactly one cycle.
// ----------------------------------------------------------------------------
module rsa_keygen_and_modexp
  import rkm_pkg::*;
#(
  parameter int unsigned PRIME_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // request
  input  logic          start,
  output logic          busy,
  input  logic          op_i,
  input  logic [NW-1:0] value_i,
  // configuration
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [CW-1:0] cfg_wdata_i,
  // result
  output logic          done_o,
  output logic [NW-1:0] result_o,
  output logic [NW-1:0] modulus_o,
  output logic [EW-1:0] public_exponent_o,
  output logic [NW-1:0] private_exponent_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Controller: one datapath operation per cycle, waits on divider done.
  rkm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Datapath: key registers, multiplier, divider; outputs are held registers.
  rkm_datapath #(
    .PRIME_BITS (PRIME_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .op_i               (op_i),
    .value_i            (value_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .result_o           (result_o),
    .modulus_o          (modulus_o),
    .public_exponent_o  (public_exponent_o),
    .private_exponent_o (private_exponent_o)
  );

endmodule
